>>> sv/lfrc_pkg.sv
package lfrc_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] START_BYTE = 8'hC5;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  typedef enum logic [2:0] {
    EV_PAY     = 3'd0,
    EV_GOOD    = 3'd1,
    EV_BAD     = 3'd2,
    EV_LONG    = 3'd3,
    EV_TIMEOUT = 3'd4
  } event_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] src_addr;
    logic [7:0] dst_addr;
    logic [7:0] ctrl_bits;
    logic [7:0] frame_type;
    logic [7:0] payload_len;
    logic       last;
  } out_item_t;

  // crc-16/modbus, reflected, one byte per call
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

>>> sv/link_frame_receiver_crc16.sv
// a result is registered: it appears on out_valid in the cycle after its input transaction is accepted
// throughput: one input transaction per cycle; the only stall comes from a held result
// register whose consumer is stalling
// reset (rst_n low, synchronous): hunting for sync, crc 0xFFFF, headers zero, timer
// disarmed, timeout_ticks back to 100, no result pending
module link_frame_receiver_crc16 #(
  parameter int unsigned MAX_PAYLOAD = 246
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lfrc_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output lfrc_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import lfrc_pkg::*;

  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  typedef enum logic [3:0] {
    ST_HUNT  = 4'd0,
    ST_START = 4'd1,
    ST_SRC   = 4'd2,
    ST_DST   = 4'd3,
    ST_CHKL  = 4'd4,
    ST_CHKH  = 4'd5,
    ST_CTRL  = 4'd6,
    ST_TYPE  = 4'd7,
    ST_LEN   = 4'd8,
    ST_PAY   = 4'd9
  } rx_state_t;

  rx_state_t   rx_state_r, rx_state_nxt;
  logic [15:0] crc_acc_r, crc_acc_nxt;
  logic [7:0]  hdr_src_r, hdr_src_nxt;
  logic [7:0]  hdr_dst_r, hdr_dst_nxt;
  logic [15:0] rx_check_r, rx_check_nxt;
  logic [7:0]  hdr_ctrl_r, hdr_ctrl_nxt;
  logic [7:0]  hdr_type_r, hdr_type_nxt;
  logic [7:0]  hdr_len_r, hdr_len_nxt;
  logic [7:0]  pay_count_r, pay_count_nxt;
  logic [15:0] timeout_left_r, timeout_left_nxt;
  logic        timer_armed_r, timer_armed_nxt;
  logic [15:0] timeout_ticks_r;

  logic        out_valid_r;
  out_item_t   out_item_r;

  logic        in_acc;
  logic        res_valid;
  event_t      res_event;
  logic [7:0]  res_data;
  logic [7:0]  res_index;
  logic        res_last;
  logic [7:0]  b;
  logic [15:0] crc_upd;
  logic [15:0] crc_ffu;
  logic [7:0]  count_inc;
  logic        do_arm;
  event_t      verdict;
  out_item_t   res_item;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign b         = in_item.rx_byte;
  assign crc_upd   = crc16_byte(crc_acc_r, b);
  assign crc_ffu   = crc16_byte(crc_acc_r, SYNC_BYTE);
  assign count_inc = pay_count_r + 8'd1;
  assign verdict   = (crc_upd == rx_check_r) ? EV_GOOD : EV_BAD;

  always_comb begin
    rx_state_nxt     = rx_state_r;
    crc_acc_nxt      = crc_acc_r;
    hdr_src_nxt      = hdr_src_r;
    hdr_dst_nxt      = hdr_dst_r;
    rx_check_nxt     = rx_check_r;
    hdr_ctrl_nxt     = hdr_ctrl_r;
    hdr_type_nxt     = hdr_type_r;
    hdr_len_nxt      = hdr_len_r;
    pay_count_nxt    = pay_count_r;
    timeout_left_nxt = timeout_left_r;
    timer_armed_nxt  = timer_armed_r;
    do_arm           = 1'b0;
    res_valid        = 1'b0;
    res_event        = EV_PAY;
    res_data         = 8'd0;
    res_index        = 8'd0;
    res_last         = 1'b0;

    if (in_item.mode) begin
      // millisecond tick
      if (timer_armed_r) begin
        if (timeout_left_r > 16'd1) begin
          timeout_left_nxt = timeout_left_r - 16'd1;
        end else begin
          timeout_left_nxt = 16'd0;
          timer_armed_nxt  = 1'b0;
          rx_state_nxt     = ST_HUNT;
          res_valid        = 1'b1;
          res_event        = EV_TIMEOUT;
          res_last         = 1'b1;
        end
      end
    end else begin
      case (rx_state_r)
        ST_START: begin
          if (b == START_BYTE) begin
            do_arm       = 1'b1;
            crc_acc_nxt  = CRC_INIT;
            rx_state_nxt = ST_SRC;
          end else if (b == SYNC_BYTE) begin
            do_arm = 1'b1;
          end else begin
            timer_armed_nxt = 1'b0;
            rx_state_nxt    = ST_HUNT;
          end
        end
        ST_SRC: begin
          do_arm       = 1'b1;
          hdr_src_nxt  = b;
          crc_acc_nxt  = crc_upd;
          rx_state_nxt = ST_DST;
        end
        ST_DST: begin
          do_arm       = 1'b1;
          hdr_dst_nxt  = b;
          crc_acc_nxt  = crc_upd;
          rx_state_nxt = ST_CHKL;
        end
        ST_CHKL: begin
          // check bytes enter the crc as 0xff
          do_arm       = 1'b1;
          rx_check_nxt = {8'h00, b};
          crc_acc_nxt  = crc_ffu;
          rx_state_nxt = ST_CHKH;
        end
        ST_CHKH: begin
          do_arm       = 1'b1;
          rx_check_nxt = {b, rx_check_r[7:0]};
          crc_acc_nxt  = crc_ffu;
          rx_state_nxt = ST_CTRL;
        end
        ST_CTRL: begin
          do_arm       = 1'b1;
          hdr_ctrl_nxt = b;
          crc_acc_nxt  = crc_upd;
          rx_state_nxt = ST_TYPE;
        end
        ST_TYPE: begin
          do_arm       = 1'b1;
          hdr_type_nxt = b;
          crc_acc_nxt  = crc_upd;
          rx_state_nxt = ST_LEN;
        end
        ST_LEN: begin
          hdr_len_nxt   = b;
          crc_acc_nxt   = crc_upd;
          pay_count_nxt = 8'd0;
          if (b > MAX_LEN) begin
            timer_armed_nxt = 1'b0;
            rx_state_nxt    = ST_HUNT;
            res_valid       = 1'b1;
            res_event       = EV_LONG;
            res_last        = 1'b1;
          end else if (b == 8'd0) begin
            timer_armed_nxt = 1'b0;
            rx_state_nxt    = ST_HUNT;
            res_valid       = 1'b1;
            res_event       = verdict;
            res_last        = 1'b1;
          end else begin
            do_arm       = 1'b1;
            rx_state_nxt = ST_PAY;
          end
        end
        ST_PAY: begin
          crc_acc_nxt   = crc_upd;
          pay_count_nxt = count_inc;
          res_valid     = 1'b1;
          res_data      = b;
          res_index     = pay_count_r;
          if (count_inc >= hdr_len_r) begin
            timer_armed_nxt = 1'b0;
            rx_state_nxt    = ST_HUNT;
            res_event       = verdict;
            res_last        = 1'b1;
          end else begin
            do_arm = 1'b1;
          end
        end
        default: begin
          // hunting, and any stray code
          if (b == SYNC_BYTE) begin
            do_arm       = 1'b1;
            rx_state_nxt = ST_START;
          end else begin
            rx_state_nxt = ST_HUNT;
          end
        end
      endcase
      if (do_arm) begin
        timeout_left_nxt = timeout_ticks_r;
        timer_armed_nxt  = 1'b1;
      end
    end
  end

  always_comb begin
    res_item.event_res   = res_event;
    res_item.data_byte   = res_data;
    res_item.byte_index  = res_index;
    res_item.src_addr    = hdr_src_nxt;
    res_item.dst_addr    = hdr_dst_nxt;
    res_item.ctrl_bits   = hdr_ctrl_nxt;
    res_item.frame_type  = hdr_type_nxt;
    res_item.payload_len = hdr_len_nxt;
    res_item.last        = res_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_state_r      <= ST_HUNT;
      crc_acc_r       <= CRC_INIT;
      hdr_src_r       <= 8'd0;
      hdr_dst_r       <= 8'd0;
      rx_check_r      <= 16'd0;
      hdr_ctrl_r      <= 8'd0;
      hdr_type_r      <= 8'd0;
      hdr_len_r       <= 8'd0;
      pay_count_r     <= 8'd0;
      timeout_left_r  <= 16'd0;
      timer_armed_r   <= 1'b0;
      timeout_ticks_r <= TIMEOUT_RESET;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_ticks_r <= cfg_wdata;
      end
      if (in_acc) begin
        rx_state_r     <= rx_state_nxt;
        crc_acc_r      <= crc_acc_nxt;
        hdr_src_r      <= hdr_src_nxt;
        hdr_dst_r      <= hdr_dst_nxt;
        rx_check_r     <= rx_check_nxt;
        hdr_ctrl_r     <= hdr_ctrl_nxt;
        hdr_type_r     <= hdr_type_nxt;
        hdr_len_r      <= hdr_len_nxt;
        pay_count_r    <= pay_count_nxt;
        timeout_left_r <= timeout_left_nxt;
        timer_armed_r  <= timer_armed_nxt;
        out_valid_r    <= res_valid;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_item_r <= res_item;
    end
  end

  a_armed_not_hunting: assert property (@(posedge clk) disable iff (!rst_n)
    timer_armed_r |-> (rx_state_r != ST_HUNT))
    else $error("timer armed while hunting");

  a_pay_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_state_r == ST_PAY) |-> (pay_count_r < hdr_len_r))
    else $error("payload count past frame length");

  a_last_matches_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.last == (out_item_r.event_res != EV_PAY)))
    else $error("last flag disagrees with event");

  a_idle_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_item.mode && !timer_armed_r) |=> !out_valid_r)
    else $error("tick without armed timer produced a result");

endmodule
